>>> sv/sacl_pkg.sv
`timescale 1ns / 1ps

package sacl_pkg;

  // Configuration register widths and indexes
  localparam int SET_BITS_W   = 3;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int CFG_DATA_W   = 6;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  localparam logic [WAYS_W-1:0] WAYS_RESET = 4'd1;

  // Access kinds
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;

  localparam int ADDR_W = 64;
  localparam int TAG_W  = 64;

  // Set index before wrapping: at most 2**SET_BITS_W - 1 bits wide
  localparam int RAW_IDX_W    = (1 << SET_BITS_W) - 1;
  localparam int RAW_IDX_SPAN = 1 << RAW_IDX_W;

  // Stream payloads
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 8;
  localparam int HIT_CNT_W = 2;

  localparam logic [HIT_CNT_W-1:0] HITS_NONE = 2'd0;
  localparam logic [HIT_CNT_W-1:0] HITS_ONE  = 2'd1;
  localparam logic [HIT_CNT_W-1:0] HITS_TWO  = 2'd2;

endpackage

>>> sv/sacl_ram.sv
`timescale 1ns / 1ps

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/sacl_queue.sv
`timescale 1ns / 1ps

module sacl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> sv/sacl_front.sv
`timescale 1ns / 1ps

module sacl_front #(
  parameter int MAX_SETS = 64,
  parameter int SW       = 6
) (
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sacl_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic [sacl_pkg::SET_BITS_W-1:0]    set_bits,
  input  logic [sacl_pkg::BLOCK_BITS_W-1:0]  block_bits,
  input  logic                               clearing,
  input  logic                               q_full,
  output logic                               q_push,
  output logic [sacl_pkg::TAG_W+SW:0]        q_data
);

  import sacl_pkg::*;

  logic [MODE_W-1:0]    mode;
  logic [ADDR_W-1:0]    address;
  logic [ADDR_W-1:0]    addr_shifted;
  logic [RAW_IDX_W-1:0] idx_mask;
  logic [RAW_IDX_W-1:0] raw_idx;
  logic [RAW_IDX_W-1:0] tag_shift;
  logic [TAG_W-1:0]     tag;
  logic [SW-1:0]        set_idx;
  logic                 modify;
  logic [SW-1:0]        wrap_tab [RAW_IDX_SPAN];

  // Set index modulo the number of sets held
  for (genvar g = 0; g < RAW_IDX_SPAN; g++) begin : g_wrap
    assign wrap_tab[g] = SW'(g % MAX_SETS);
  end

  assign mode    = s_tdata[MODE_W-1:0];
  assign address = s_tdata[MODE_W +: ADDR_W];
  assign modify  = (mode == MODE_MODIFY);

  assign addr_shifted = address >> block_bits;
  assign idx_mask     = RAW_IDX_W'((8'd1 << set_bits) - 8'd1);
  assign raw_idx      = addr_shifted[RAW_IDX_W-1:0] & idx_mask;
  assign set_idx      = wrap_tab[raw_idx];

  assign tag_shift = RAW_IDX_W'(block_bits) + RAW_IDX_W'(set_bits);
  assign tag       = (tag_shift >= RAW_IDX_W'(64)) ? '0 : (address >> tag_shift[5:0]);

  assign s_tready = !q_full && !clearing;
  assign q_push   = s_tvalid && s_tready;
  assign q_data   = {tag, set_idx, modify};

endmodule

>>> sv/sacl_back.sv
`timescale 1ns / 1ps

module sacl_back #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8,
  parameter int SW       = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [sacl_pkg::WAYS_W-1:0]      ways,
  input  logic                             q_empty,
  input  logic [sacl_pkg::TAG_W+SW:0]      q_head,
  output logic                             q_pop,
  output logic                             clearing,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sacl_pkg::M_TDATA_W-1:0]   m_tdata
);

  import sacl_pkg::*;

  localparam int RW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WIW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYW = 1 + RW + TAG_W;
  localparam int ROWW = MAX_WAYS * WAYW;
  localparam logic [RW:0] RANK_CAP = (RW + 1)'(MAX_WAYS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t          state;
  logic [SW-1:0]   clear_addr;
  logic [SW-1:0]   cur_idx;
  logic [TAG_W-1:0] cur_tag;
  logic            cur_modify;

  logic            ram_we;
  logic [SW-1:0]   ram_waddr;
  logic [ROWW-1:0] ram_wdata;
  logic [ROWW-1:0] row_rd;
  logic [ROWW-1:0] row_new;

  logic [MAX_WAYS-1:0] way_en;
  logic [MAX_WAYS-1:0] line_v;
  logic [RW-1:0]       line_rk  [MAX_WAYS];
  logic [TAG_W-1:0]    line_tag [MAX_WAYS];

  logic            hit;
  logic [WIW-1:0]  hit_way;
  logic            found;
  logic [WIW-1:0]  free_way;
  logic [RW-1:0]   best;
  logic [WIW-1:0]  victim;
  logic [WIW-1:0]  sel_way;
  logic [RW:0]     limit;
  logic            evict;
  logic            out_free;
  logic            done;
  logic [HIT_CNT_W-1:0] hits;

  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign out_free = !m_tvalid || m_tready;
  assign done     = (state == ST_UPDATE) && out_free;

  assign ram_we    = clearing || done;
  assign ram_waddr = clearing ? clear_addr : cur_idx;
  assign ram_wdata = clearing ? '0 : row_new;

  sacl_ram #(
    .WIDTH(ROWW),
    .DEPTH(MAX_SETS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (q_pop),
    .raddr(q_head[SW:1]),
    .rdata(row_rd)
  );

  // Ways in use: zero counts as one, anything above the array saturates
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      way_en[i] = (ways == '0) ? (i == 0) : (5'(i) < {1'b0, ways});
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      line_tag[i] = row_rd[i*WAYW +: TAG_W];
      line_rk[i]  = row_rd[i*WAYW + TAG_W +: RW];
      line_v[i]   = row_rd[i*WAYW + TAG_W + RW];
    end
  end

  // Lookup, free-way search and victim choice over the set just read
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    found    = 1'b0;
    free_way = '0;
    best     = '0;
    victim   = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!hit && way_en[i] && line_v[i] && (line_tag[i] == cur_tag)) begin
        hit     = 1'b1;
        hit_way = WIW'(i);
      end
      if (!found && way_en[i] && !line_v[i]) begin
        found    = 1'b1;
        free_way = WIW'(i);
      end
      if (way_en[i] && (line_rk[i] >= best)) begin
        best   = line_rk[i];
        victim = WIW'(i);
      end
    end
    evict = !hit && !found;
    if (hit) begin
      sel_way = hit_way;
      limit   = {1'b0, line_rk[hit_way]};
    end else if (found) begin
      sel_way = free_way;
      limit   = {1'b1, {RW{1'b0}}};
    end else begin
      sel_way = victim;
      limit   = {1'b0, best};
    end
  end

  // Recency update and write-back row
  always_comb begin
    row_new = row_rd;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WIW'(i) == sel_way) begin
        row_new[i*WAYW +: WAYW] = {1'b1, {RW{1'b0}}, cur_tag};
      end else if (way_en[i] && line_v[i] && ({1'b0, line_rk[i]} < limit) &&
                   ({1'b0, line_rk[i]} < RANK_CAP)) begin
        row_new[i*WAYW + TAG_W +: RW] = line_rk[i] + RW'(1);
      end
    end
  end

  always_comb begin
    if (hit) begin
      hits = cur_modify ? HITS_TWO : HITS_ONE;
    end else begin
      hits = cur_modify ? HITS_ONE : HITS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + SW'(1);
          if (clear_addr == SW'(MAX_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_modify <= q_head[0];
      cur_idx    <= q_head[SW:1];
      cur_tag    <= q_head[SW+1 +: TAG_W];
    end
    if (done) begin
      m_tdata <= {4'b0000, evict, !hit, hits};
    end
  end

endmodule

>>> sv/set_assoc_cache_lru_sim.sv
`timescale 1ns / 1ps

// Tag-only set-associative cache with LRU replacement. Each transfer on the
// s_ side carries an access (load, store or modify) and a byte address; each
// access returns exactly one result on the m_ side with its hit count, miss
// flag and eviction flag. After reset the set array is swept clear, one set
// per cycle, through all MAX_SETS sets; s_tready stays low until that is done,
// while configuration writes are taken throughout. The back end reads an
// access's set row from the tag RAM, then compares the tags of the ways in
// use, picks the way and writes the row back once the m_ side is free. The
// front end decodes set and tag and buffers up to two accesses, so input and
// output stall independently. Configure only while no access is in flight.

module set_assoc_cache_lru_sim #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [sacl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data,
  // access stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sacl_pkg::S_TDATA_W-1:0]     s_tdata,  // mode[1:0], address[65:2]
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sacl_pkg::M_TDATA_W-1:0]     m_tdata   // hit_count[1:0], miss_flag[2],
                                                       // eviction_flag[3]
);

  import sacl_pkg::*;

  localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int QW = TAG_W + SW + 1;

  logic [SET_BITS_W-1:0]   set_bits;
  logic [WAYS_W-1:0]       ways;
  logic [BLOCK_BITS_W-1:0] block_bits;

  logic          clearing;
  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  logic [QW-1:0] q_data;
  logic [QW-1:0] q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= '0;
      ways       <= WAYS_RESET;
      block_bits <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits   <= cfg_data[SET_BITS_W-1:0];
        CFG_WAYS:       ways       <= cfg_data[WAYS_W-1:0];
        CFG_BLOCK_BITS: block_bits <= cfg_data[BLOCK_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  sacl_front #(
    .MAX_SETS(MAX_SETS),
    .SW      (SW)
  ) u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .set_bits  (set_bits),
    .block_bits(block_bits),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  sacl_queue #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  sacl_back #(
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS),
    .SW      (SW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .ways    (ways),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .clearing(clearing),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("access accepted during set array clear");

  a_hit_result_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[2]) |-> (!m_tdata[3] && (m_tdata[1:0] != HITS_NONE)))
    else $error("hit result with eviction or no hit count");

  a_hit_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("hit count out of range");
`endif

endmodule

>>> tb/cache_result_checker.sv
`timescale 1ns / 1ps

module cache_result_checker #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sacl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [sacl_pkg::S_TDATA_W-1:0]   s_tdata,   // mode[1:0], address[65:2]
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [sacl_pkg::M_TDATA_W-1:0]   m_tdata,   // hit_count[1:0], miss_flag[2],
                                                      // eviction_flag[3]
  output int                               mismatches,
  output int                               pending
);
  import sacl_pkg::*;

  localparam int LINES = MAX_SETS * MAX_WAYS;

  // packed so that the low nibble of m_tdata maps straight on
  typedef struct packed {
    logic                 evict;
    logic                 miss;
    logic [HIT_CNT_W-1:0] hits;
  } access_outcome_t;

  access_outcome_t pending_outcomes[$];

  logic                    line_ok  [LINES];
  logic [TAG_W-1:0]        line_tag [LINES];
  int unsigned             line_age [LINES];
  logic [SET_BITS_W-1:0]   set_bits_q;
  logic [WAYS_W-1:0]       ways_q;
  logic [BLOCK_BITS_W-1:0] block_bits_q;

  // Valid lines in use younger than limit get one step older; way becomes newest.
  function automatic void age_lines(input int unsigned base, input int unsigned n,
                                    input int unsigned way, input int unsigned limit);
    int unsigned k;
    for (int unsigned i = 0; i < n; i++) begin
      k = base + i;
      if (i != way && line_ok[k] && line_age[k] < limit && line_age[k] < MAX_WAYS - 1)
        line_age[k]++;
    end
    line_age[base + way] = 0;
  endfunction

  function automatic access_outcome_t cache_lookup(input logic [MODE_W-1:0] md,
                                                   input logic [ADDR_W-1:0] addr);
    access_outcome_t res;
    logic [ADDR_W-1:0] idx;
    logic [TAG_W-1:0]  tag;
    int unsigned n, base, way, best, shift;
    logic hit, found, modify;
    n = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS) ? MAX_WAYS : ways_q);
    shift = int'(block_bits_q) + int'(set_bits_q);
    idx = (addr >> block_bits_q) & ((64'd1 << set_bits_q) - 64'd1);
    idx = idx % MAX_SETS;
    tag = (shift >= 64) ? '0 : (addr >> shift);
    base = int'(idx) * MAX_WAYS;
    modify = (md == MODE_MODIFY);
    hit = 1'b0;
    found = 1'b0;
    way = 0;
    res = '0;

    // lowest matching way wins when tags are duplicated
    for (int unsigned i = 0; i < n; i++)
      if (!hit && line_ok[base + i] && line_tag[base + i] == tag) begin
        hit = 1'b1;
        way = i;
      end

    if (hit) begin
      age_lines(base, n, way, line_age[base + way]);
    end else begin
      for (int unsigned i = 0; i < n; i++)
        if (!found && !line_ok[base + i]) begin
          found = 1'b1;
          way = i;
        end
      if (found) begin
        line_ok[base + way]  = 1'b1;
        line_tag[base + way] = tag;
        age_lines(base, n, way, MAX_WAYS);
      end else begin
        // oldest way, ties go to the higher way number
        best = 0;
        for (int unsigned i = 0; i < n; i++)
          if (line_age[base + i] >= best) begin
            best = line_age[base + i];
            way = i;
          end
        res.evict = 1'b1;
        line_tag[base + way] = tag;
        age_lines(base, n, way, best);
      end
    end

    res.miss = !hit;
    if (hit)
      res.hits = modify ? HITS_TWO : HITS_ONE;
    else
      res.hits = modify ? HITS_ONE : HITS_NONE;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    access_outcome_t want, got;
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        line_ok[i]  = 1'b0;
        line_tag[i] = '0;
        line_age[i] = 0;
      end
      set_bits_q   = '0;
      ways_q       = WAYS_RESET;
      block_bits_q = '0;
      pending_outcomes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits_q   = cfg_data[SET_BITS_W-1:0];
          CFG_WAYS:       ways_q       = cfg_data[WAYS_W-1:0];
          CFG_BLOCK_BITS: block_bits_q = cfg_data[BLOCK_BITS_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        got = m_tdata[3:0];
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          if (got.hits !== want.hits) begin
            $display("%0t: hit_count expected %0d got %0d", $time, want.hits, got.hits);
            mismatches++;
          end
          if (got.miss !== want.miss) begin
            $display("%0t: miss_flag expected %0d got %0d", $time, want.miss, got.miss);
            mismatches++;
          end
          if (got.evict !== want.evict) begin
            $display("%0t: eviction_flag expected %0d got %0d", $time, want.evict, got.evict);
            mismatches++;
          end
        end
      end

      if (s_tvalid && s_tready)
        pending_outcomes.push_back(cache_lookup(s_tdata[MODE_W-1:0],
                                                s_tdata[MODE_W +: ADDR_W]));
    end
    pending = pending_outcomes.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sacl_pkg::*;

  localparam int MAX_SETS    = 64;
  localparam int MAX_WAYS    = 8;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 125;

  // unused encoding, behaves as a load
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;

  int mismatches;
  int pending_results;
  int gap_chance;
  int stall_chance;
  int stall_left;
  int quiet_cycles;

  logic [SET_BITS_W-1:0]   cur_sb;
  logic [WAYS_W-1:0]       cur_w;
  logic [BLOCK_BITS_W-1:0] cur_bb;

  set_assoc_cache_lru_sim #(
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  cache_result_checker #(
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .pending(pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure in bursts that start at random
  always @(posedge clk) begin
    if (stall_chance == 0) begin
      stall_left <= 0;
      m_tready   <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if ($urandom_range(0, stall_chance - 1) == 0) begin
      stall_left <= int'($urandom_range(0, 9));
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_access(input logic [MODE_W-1:0] md, input logic [ADDR_W-1:0] addr);
    if (gap_chance != 0 && $urandom_range(0, gap_chance - 1) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - ADDR_W - MODE_W){1'b0}}, addr, md};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // drain everything in flight before touching the registers
  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [SET_BITS_W-1:0] sb, input logic [WAYS_W-1:0] w,
                            input logic [BLOCK_BITS_W-1:0] bb);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SET_BITS;
    cfg_data  <= CFG_DATA_W'(sb);
    @(posedge clk);
    cfg_index <= CFG_WAYS;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_BLOCK_BITS;
    cfg_data  <= bb;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sb = sb;
    cur_w  = w;
    cur_bb = bb;
  endtask

  // Mostly a small pool of tags and sets so lines get reused and evicted;
  // bit 6 of the set part aliases onto the same set when set_bits is 7.
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] off, set_part, tag_part;
    int sel, bit_no, shift;
    shift = int'(cur_bb) + int'(cur_sb);
    sel = $urandom_range(0, 19);
    bit_no = $urandom_range(0, ADDR_W - 1);
    if (sel < 14) begin
      off      = {$urandom, $urandom} & ((64'd1 << cur_bb) - 64'd1);
      set_part = 64'($urandom_range(0, 3) | ($urandom_range(0, 1) << 6));
      set_part = (set_part & ((64'd1 << cur_sb) - 64'd1)) << cur_bb;
      tag_part = 64'($urandom_range(0, cur_w + 2)) << shift;
      return tag_part | set_part | off;
    end
    if (sel < 18)
      return {$urandom, $urandom};
    if (sel == 18)
      return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return ($urandom_range(0, 1) != 0) ? (64'd1 << bit_no) : ~(64'd1 << bit_no);
  endfunction

  initial begin : stimulus
    logic [SET_BITS_W-1:0]   sb;
    logic [WAYS_W-1:0]       w;
    logic [BLOCK_BITS_W-1:0] bb;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    gap_chance   = 4;
    stall_chance = 4;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    cur_sb = '0;
    cur_w  = WAYS_RESET;
    cur_bb = '0;

    // reset registers: single set, one way, byte blocks
    push_access(MODE_LOAD, 64'd0);
    push_access(MODE_LOAD, 64'd0);
    push_access(MODE_STORE, 64'd0);
    push_access(MODE_MODIFY, 64'd0);
    push_access(MODE_MODIFY, 64'd1);
    push_access(MODE_SPARE, 64'd1);
    push_access(MODE_LOAD, '1);
    push_access(MODE_STORE, 64'h8000_0000_0000_0000);
    settle();

    // duplicate tag: way 0 re-filled through a one-way window, then both visible
    set_config(3'd0, 4'd2, 6'd0);
    push_access(MODE_LOAD, 64'd0);
    settle();
    set_config(3'd0, 4'd1, 6'd0);
    push_access(MODE_LOAD, 64'd0);
    settle();
    set_config(3'd0, 4'd2, 6'd0);
    push_access(MODE_LOAD, 64'd0);
    push_access(MODE_LOAD, 64'h8000_0000_0000_0000);
    settle();

    // set index wrap and saturated way count
    set_config(3'd7, 4'd15, 6'd0);
    push_access(MODE_LOAD, 64'd64);
    push_access(MODE_LOAD, 64'd0);
    push_access(MODE_MODIFY, 64'h7f);
    settle();

    // zero ways, largest offset
    set_config(3'd0, 4'd0, 6'd63);
    push_access(MODE_LOAD, 64'h8000_0000_0000_0000);
    push_access(MODE_LOAD, 64'd0);
    push_access(MODE_STORE, 64'h7fff_ffff_ffff_ffff);
    settle();

    // total shift past the address width: tag collapses to zero
    set_config(3'd7, 4'd8, 6'd63);
    push_access(MODE_LOAD, '1);
    push_access(MODE_MODIFY, '1);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin sb = 3'd0; w = 4'd8;  bb = 6'd0;  end
        1: begin sb = 3'd6; w = 4'd1;  bb = 6'd32; end
        2: begin sb = 3'd7; w = 4'd15; bb = 6'd63; end
        3: begin sb = 3'd2; w = 4'd0;  bb = 6'd5;  end
        default: begin
          sb = SET_BITS_W'($urandom_range(0, 7));
          w  = WAYS_W'($urandom_range(0, 15));
          bb = ($urandom_range(0, 3) == 0) ? BLOCK_BITS_W'($urandom_range(0, 63)) :
                                             BLOCK_BITS_W'($urandom_range(0, 12));
        end
      endcase
      if (ph == PHASES - 1) begin
        gap_chance   = 0;
        stall_chance = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_chance = 0;
          1: gap_chance = 2;
          default: gap_chance = 6;
        endcase
        case ($urandom_range(0, 2))
          0: stall_chance = 0;
          1: stall_chance = 2;
          default: stall_chance = 6;
        endcase
      end
      set_config(sb, w, bb);
      repeat (PHASE_ITEMS) push_access(MODE_W'($urandom_range(0, 3)), pick_address());
      settle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
